FILE: src/tpct_pkg.sv
package tpct_pkg;

    // Default number of buckets in the table.
    localparam int unsigned BUCKETS_DEFAULT = 4096;

    // Width and reset value of the bucket count register.
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_RESET = 4096;

    // Operation codes.
    localparam logic [1:0] FN_PROBE = 2'd0;
    localparam logic [1:0] FN_STORE = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // One command beat.
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] hash_key;
        logic [31:0] white_men;
        logic [31:0] black_men;
        logic [31:0] king_marks;
        logic [7:0]  ply_depth;
        logic [63:0] count_in;
    } tpct_in_t;

    // One result beat.
    typedef struct packed {
        logic        hit;
        logic [63:0] count_out;
    } tpct_out_t;

    // One slot of a bucket.
    typedef struct packed {
        logic [31:0] white;
        logic [31:0] black;
        logic [31:0] kings;
        logic [7:0]  depth;
        logic [63:0] count;
    } tpct_slot_t;

    // One bucket, both slots, as one memory row.
    typedef struct packed {
        tpct_slot_t s1;
        tpct_slot_t s0;
    } tpct_row_t;

    localparam int unsigned ROW_W = $bits(tpct_row_t);

endpackage

FILE: src/two_slot_position_count_table_unit.sv
// Probe and store run a bit-serial reduction of the 64-bit hash key, one memory read,
// one evaluate step and then the registered done strobe.
// Clear writes one row per cycle across all BUCKETS rows; an unused code answers at once.
// Reset and every bucket count write run a clearing pass over all BUCKETS rows with busy high.
// A new command is accepted in the cycle its predecessor's result is shown.
// Results are strobed for one cycle by done; the receiver cannot stall.
module two_slot_position_count_table_unit
    import tpct_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tpct_in_t         item,
    output logic             done,
    output tpct_out_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int unsigned AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned NW = $clog2(BUCKETS + 1);
    localparam int unsigned CW = (NW > CFG_W) ? NW : CFG_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] buckets_reg, buckets_next;
    logic [AW-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic             clr_pend_reg, clr_pend_next;
    logic [5:0]       bit_cnt_reg, bit_cnt_next;
    logic [63:0]      key_reg, key_next;
    logic [NW-1:0]    rem_reg, rem_next;
    tpct_in_t         item_reg, item_next;
    logic             done_reg, done_next;
    tpct_out_t        result_reg, result_next;

    logic [CW-1:0]    cfg_wide;
    logic [NW-1:0]    n_eff;
    logic [NW:0]      shifted;
    logic [NW:0]      divisor;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    tpct_row_t        ram_wdata;
    logic             ram_re;
    logic [ROW_W-1:0] ram_rdata;
    tpct_row_t        row;
    tpct_slot_t       new_slot;
    logic             match1, match0;

    // Effective bucket count: zero acts as one, values above BUCKETS act as BUCKETS.
    always_comb
    begin
        cfg_wide = CW'(buckets_reg);
        if (cfg_wide == '0)
        begin
            n_eff = NW'(1);
        end
        else if (cfg_wide > CW'(BUCKETS))
        begin
            n_eff = NW'(BUCKETS);
        end
        else
        begin
            n_eff = NW'(cfg_wide);
        end
    end

    // Shared restoring step of the key reduction, one key bit per cycle.
    assign shifted = {rem_reg, key_reg[63]};
    assign divisor = {1'b0, n_eff};

    // Slot comparison against the command held in the item register.
    assign row      = tpct_row_t'(ram_rdata);
    assign match1   = (row.s1.white == item_reg.white_men) &&
                      (row.s1.black == item_reg.black_men) &&
                      (row.s1.kings == item_reg.king_marks) &&
                      (row.s1.depth == item_reg.ply_depth);
    assign match0   = (row.s0.white == item_reg.white_men) &&
                      (row.s0.black == item_reg.black_men) &&
                      (row.s0.kings == item_reg.king_marks) &&
                      (row.s0.depth == item_reg.ply_depth);
    assign new_slot = '{white: item_reg.white_men, black: item_reg.black_men,
                        kings: item_reg.king_marks, depth: item_reg.ply_depth,
                        count: item_reg.count_in};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        buckets_next   = buckets_reg;
        sweep_cnt_next = sweep_cnt_reg;
        clr_pend_next  = clr_pend_reg;
        bit_cnt_next   = bit_cnt_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        item_next      = item_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_cnt_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next    = item;
                    key_next     = item.hash_key;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    case (item.func)
                        FN_PROBE, FN_STORE:
                        begin
                            state_next = ST_DIV;
                        end
                        FN_CLEAR:
                        begin
                            state_next     = ST_SWEEP;
                            sweep_cnt_next = '0;
                            clr_pend_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                if (shifted >= divisor)
                begin
                    rem_next = NW'(shifted - divisor);
                end
                else
                begin
                    rem_next = NW'(shifted);
                end
                key_next     = {key_reg[62:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd63)
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                done_next   = 1'b1;
                result_next = '0;
                if (item_reg.func == FN_PROBE)
                begin
                    if (match1)
                    begin
                        result_next.hit       = 1'b1;
                        result_next.count_out = row.s1.count;
                    end
                    else if (match0)
                    begin
                        result_next.hit       = 1'b1;
                        result_next.count_out = row.s0.count;
                    end
                end
                else
                begin
                    // Replace slot 0 only on strictly greater depth.
                    ram_we    = 1'b1;
                    ram_waddr = rem_reg[AW-1:0];
                    ram_wdata = row;
                    if (item_reg.ply_depth > row.s0.depth)
                    begin
                        ram_wdata.s0 = new_slot;
                    end
                    else
                    begin
                        ram_wdata.s1 = new_slot;
                    end
                end
                state_next = ST_IDLE;
            end

            ST_SWEEP:
            begin
                ram_we         = 1'b1;
                ram_waddr      = sweep_cnt_reg;
                ram_wdata      = '0;
                sweep_cnt_next = sweep_cnt_reg + AW'(1);
                if (sweep_cnt_reg == AW'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                    if (clr_pend_reg)
                    begin
                        done_next     = 1'b1;
                        result_next   = '0;
                        clr_pend_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A bucket count write restarts the clearing pass.
        if (cfg_valid && cfg_ready)
        begin
            buckets_next   = cfg_data;
            state_next     = ST_SWEEP;
            sweep_cnt_next = '0;
            clr_pend_next  = 1'b0;
        end
    end

    // Control registers; reset starts a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            buckets_reg   <= CFG_W'(CFG_RESET);
            sweep_cnt_reg <= '0;
            clr_pend_reg  <= 1'b0;
            bit_cnt_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buckets_reg   <= buckets_next;
            sweep_cnt_reg <= sweep_cnt_next;
            clr_pend_reg  <= clr_pend_next;
            bit_cnt_reg   <= bit_cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        rem_reg    <= rem_next;
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    // Bucket rows, both slots side by side.
    tpct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rem_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

endmodule

FILE: src/tpct_ram.sv
module tpct_ram
    import tpct_pkg::*;
#(
    parameter int unsigned WIDTH = ROW_W,
    parameter int unsigned DEPTH = BUCKETS_DEFAULT,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
